>>> rtl/nco_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the tone generator.
// No dependencies; imported by nco_sine_fill, nco_waveform_generator and the testbench.
package nco_pkg;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int AMP_W      = 15;

  // Quarter-wave table entries are magnitudes up to 32767.
  localparam int TBL_W = 15;

  // Taylor evaluation of the quarter sine in Q62 fixed point.
  localparam logic [63:0] HALF_PI_Q62  = 64'h6487_ED51_10B4_611A;
  localparam logic [3:0]  TAYLOR_TERMS = 4'd13;
  localparam int          DIV_W        = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP   = 3'd0,
    REG_PHASE_OFFSET = 3'd1,
    REG_AMPLITUDE    = 3'd2,
    REG_WAVEFORM     = 3'd3
  } cfg_reg_e;

  // Divisor (2n)(2n+1) of Taylor term n.
  function automatic logic [DIV_W-1:0] taylor_divisor(input logic [3:0] n);
    logic [DIV_W-1:0] d;
    case (n)
      4'd1:    d = 10'd6;
      4'd2:    d = 10'd20;
      4'd3:    d = 10'd42;
      4'd4:    d = 10'd72;
      4'd5:    d = 10'd110;
      4'd6:    d = 10'd156;
      4'd7:    d = 10'd210;
      4'd8:    d = 10'd272;
      4'd9:    d = 10'd342;
      4'd10:   d = 10'd420;
      4'd11:   d = 10'd506;
      4'd12:   d = 10'd600;
      4'd13:   d = 10'd702;
      default: d = 10'd1;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/nco_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module nco_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/nco_sine_fill.sv
`timescale 1ns / 1ps
// Quarter-wave table builder: evaluates round(32767*sin) by a Q62 Taylor series
// on a shared 32x32 multiplier and a radix-256 divider. Depends on nco_pkg.
module nco_sine_fill import nco_pkg::*; #(
  parameter int QBITS = 14,
  localparam int AW = QBITS + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             busy_o,
  output logic             we_o,
  output logic [AW-1:0]    addr_o,
  output logic [TBL_W-1:0] data_o
);

  typedef enum logic [2:0] {F_MUL, F_POST, F_DIV, F_ACC, F_ROUND, F_DONE} fstate_e;
  typedef enum logic [1:0] {PH_X, PH_X2, PH_TERM} mphase_e;

  localparam logic [AW-1:0] LAST_M = {1'b1, {QBITS{1'b0}}};

  fstate_e          state_q;
  mphase_e          phase_q;
  logic [AW-1:0]    m_q;
  logic [3:0]       n_q;
  logic [2:0]       mcnt_q;
  logic [2:0]       dcnt_q;
  logic [127:0]     acc_q;
  logic [63:0]      pp_q;
  logic [63:0]      term_q;
  logic [63:0]      x2_q;
  logic [63:0]      sum_q;
  logic [63:0]      dq_q;
  logic [DIV_W-1:0] rem_q;
  logic             we_q;
  logic [AW-1:0]    addr_q;
  logic [TBL_W-1:0] data_q;

  logic [63:0]      frac;
  logic [63:0]      op_a;
  logic [63:0]      op_b;
  logic [31:0]      a_half;
  logic [31:0]      b_half;
  logic [63:0]      pp_d;
  logic [2:0]       pk;
  logic [127:0]     pp_sh;
  logic [127:0]     acc_d;
  logic [63:0]      mul_res;
  logic [DIV_W-1:0] divisor;
  logic [DIV_W-1:0] rem_d;
  logic [63:0]      dq_d;
  logic [DIV_W:0]   trial;
  logic [63:0]      sum_d;
  logic [41:0]      s40;
  logic [57:0]      scaled;
  logic [TBL_W-1:0] round_d;

  // Operand select for the shared multiplier.
  assign frac = 64'(m_q) << (62 - QBITS);

  always_comb begin
    case (phase_q)
      PH_X: begin
        op_a = HALF_PI_Q62;
        op_b = frac;
      end
      PH_X2: begin
        op_a = term_q;
        op_b = term_q;
      end
      default: begin
        op_a = term_q;
        op_b = x2_q;
      end
    endcase
  end

  // One 32x32 partial product per cycle; accumulate it in the following cycle.
  assign a_half = mcnt_q[1] ? op_a[63:32] : op_a[31:0];
  assign b_half = mcnt_q[0] ? op_b[63:32] : op_b[31:0];
  assign pp_d   = 64'(a_half) * 64'(b_half);
  assign pk     = mcnt_q - 3'd1;

  always_comb begin
    case (pk[1:0])
      2'b00:         pp_sh = {64'b0, pp_q};
      2'b01, 2'b10:  pp_sh = {64'b0, pp_q} << 32;
      default:       pp_sh = {64'b0, pp_q} << 64;
    endcase
  end

  assign acc_d   = acc_q + pp_sh;
  assign mul_res = acc_q[125:62];

  // Eight quotient bits per cycle; the remainder stays below the divisor.
  assign divisor = taylor_divisor(n_q);

  always_comb begin
    rem_d = rem_q;
    dq_d  = dq_q;
    trial = '0;
    for (int s = 0; s < 8; s++) begin
      trial = {rem_d, dq_d[63]};
      dq_d  = {dq_d[62:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_d    = DIV_W'(trial - {1'b0, divisor});
        dq_d[0]  = 1'b1;
      end else begin
        rem_d = trial[DIV_W-1:0];
      end
    end
  end

  // Odd terms subtract, even terms add.
  assign sum_d = n_q[0] ? (sum_q - dq_q) : (sum_q + dq_q);

  // round(32767 * sum) from the top 42 bits of the Q62 sum.
  assign s40     = sum_q[63:22];
  assign scaled  = 58'({s40, 15'b0}) - 58'(s40) + (58'(1) << 39);
  assign round_d = scaled[54:40];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_MUL;
      phase_q <= PH_X;
      m_q     <= '0;
      n_q     <= 4'd1;
      mcnt_q  <= '0;
      dcnt_q  <= '0;
      acc_q   <= '0;
      we_q    <= 1'b0;
    end else begin
      we_q <= 1'b0;
      case (state_q)
        F_MUL: begin
          pp_q <= pp_d;
          if (mcnt_q != 3'd0) begin
            acc_q <= acc_d;
          end
          if (mcnt_q == 3'd4) begin
            state_q <= F_POST;
          end else begin
            mcnt_q <= mcnt_q + 3'd1;
          end
        end
        F_POST: begin
          case (phase_q)
            PH_X: begin
              term_q  <= mul_res;
              phase_q <= PH_X2;
              acc_q   <= '0;
              mcnt_q  <= '0;
              state_q <= F_MUL;
            end
            PH_X2: begin
              x2_q    <= mul_res;
              sum_q   <= term_q;
              n_q     <= 4'd1;
              phase_q <= PH_TERM;
              acc_q   <= '0;
              mcnt_q  <= '0;
              state_q <= F_MUL;
            end
            default: begin
              dq_q    <= mul_res;
              rem_q   <= '0;
              dcnt_q  <= '0;
              state_q <= F_DIV;
            end
          endcase
        end
        F_DIV: begin
          dq_q   <= dq_d;
          rem_q  <= rem_d;
          dcnt_q <= dcnt_q + 3'd1;
          if (dcnt_q == 3'd7) begin
            state_q <= F_ACC;
          end
        end
        F_ACC: begin
          term_q <= dq_q;
          sum_q  <= sum_d;
          if (n_q == TAYLOR_TERMS) begin
            state_q <= F_ROUND;
          end else begin
            n_q     <= n_q + 4'd1;
            acc_q   <= '0;
            mcnt_q  <= '0;
            state_q <= F_MUL;
          end
        end
        F_ROUND: begin
          we_q   <= 1'b1;
          addr_q <= m_q;
          data_q <= round_d;
          if (m_q == LAST_M) begin
            state_q <= F_DONE;
          end else begin
            m_q     <= m_q + AW'(1);
            phase_q <= PH_X;
            acc_q   <= '0;
            mcnt_q  <= '0;
            state_q <= F_MUL;
          end
        end
        F_DONE: begin
          state_q <= F_DONE;
        end
        default: begin
          state_q <= F_DONE;
        end
      endcase
    end
  end

  // Stay busy until the last write has landed in the table.
  assign busy_o = (state_q != F_DONE) || we_q;
  assign we_o   = we_q;
  assign addr_o = addr_q;
  assign data_o = data_q;

endmodule

>>> rtl/nco_waveform_generator.sv
`timescale 1ns / 1ps
// Top level of the numerically controlled tone generator.
// Depends on nco_pkg, nco_ram and nco_sine_fill.
//
// Usage:
//   Each transfer on the input channel (in_valid_i / in_stall_o, field restart_i)
//   requests one sample; restart_i clears the phase accumulator first. Each
//   request yields exactly one transfer on the output channel (out_valid_o /
//   out_stall_i, fields real_part_o and imag_part_o): A*cos and A*sin of the
//   phase in sine mode, +A/-A and zero in square mode.
//   A request passes the stage 1, stage 2 and output registers before out_valid_o
//   rises; throughput is one sample per clock while the output is not stalled,
//   set by the two table read ports (one per component).
//   Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i); it must be
//   written only while no sample is in flight, which the block does not enforce.
//   After reset the quarter-wave table is computed by a Taylor-series engine over
//   2^(TABLE_BITS-2)+1 entries. in_stall_o stays high until it is done.
//   When the receiver stalls, hold the output register; the pipeline keeps
//   taking requests until every stage holds one, then stalls the input.
module nco_waveform_generator import nco_pkg::*; #(
  parameter int PHASE_BITS  = 32,
  parameter int TABLE_BITS  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] real_part_o,
  output logic signed [SAMPLE_BITS-1:0] imag_part_o
);

  localparam int QBITS = TABLE_BITS - 2;
  localparam int AW    = QBITS + 1;
  localparam int DEPTH = (1 << QBITS) + 1;
  // Width for the saturation compare: covers 17-bit scaled values and the port.
  localparam int CW    = ((SAMPLE_BITS > 17) ? SAMPLE_BITS : 17) + 1;
  localparam logic signed [CW-1:0] HI_C = CW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [CW-1:0] LO_C = CW'(-(1 << (SAMPLE_BITS - 1)));
  localparam logic [AW-1:0]         QSIZE_A = {1'b1, {QBITS{1'b0}}};
  localparam logic [TABLE_BITS-1:0] QSIZE_K = TABLE_BITS'(1 << QBITS);

  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [16:0] v);
    logic signed [CW-1:0] w;
    w = {{(CW-17){v[16]}}, v};
    if (w > HI_C) begin
      w = HI_C;
    end else if (w < LO_C) begin
      w = LO_C;
    end
    return SAMPLE_BITS'(w);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] step_q;
  logic [CFG_DATA_W-1:0] offset_q;
  logic [AMP_W-1:0]      amp_q;
  logic                  wave_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      offset_q <= '0;
      amp_q    <= '0;
      wave_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PHASE_STEP:   step_q   <= cfg_data_i;
        REG_PHASE_OFFSET: offset_q <= cfg_data_i;
        REG_AMPLITUDE:    amp_q    <= cfg_data_i[AMP_W-1:0];
        REG_WAVEFORM:     wave_q   <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Table build after reset
  // ---------------------------------------------------------------------------
  logic             fill_busy;
  logic             fill_we;
  logic [AW-1:0]    fill_addr;
  logic [TBL_W-1:0] fill_data;

  nco_sine_fill #(
    .QBITS (QBITS)
  ) u_fill (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (fill_busy),
    .we_o   (fill_we),
    .addr_o (fill_addr),
    .data_o (fill_data)
  );

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its successor moves
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic s2_valid_q;
  logic out_valid_q;
  logic en1;
  logic en2;
  logic en3;
  logic accept;

  assign en3        = !out_valid_q || !out_stall_i;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_stall_o = fill_busy || !en1;
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Stage 0: phase accumulator and quarter-wave addressing
  // ---------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] acc_q;
  logic [PHASE_BITS-1:0] acc_cur;
  logic [PHASE_BITS-1:0] phase;
  logic [TABLE_BITS-1:0] k_sin;
  logic [TABLE_BITS-1:0] k_cos;
  logic [AW-1:0]         addr_sin;
  logic [AW-1:0]         addr_cos;

  assign acc_cur = restart_i ? '0 : acc_q;
  assign phase   = acc_cur + PHASE_BITS'(offset_q);
  assign k_sin   = phase[PHASE_BITS-1 -: TABLE_BITS];
  assign k_cos   = k_sin + QSIZE_K;

  // Mirror the index in the second and fourth quadrants.
  assign addr_sin = k_sin[QBITS] ? (QSIZE_A - {1'b0, k_sin[QBITS-1:0]})
                                 : {1'b0, k_sin[QBITS-1:0]};
  assign addr_cos = k_cos[QBITS] ? (QSIZE_A - {1'b0, k_cos[QBITS-1:0]})
                                 : {1'b0, k_cos[QBITS-1:0]};

  // Advance the accumulator once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (accept) begin
      acc_q <= acc_cur + PHASE_BITS'(step_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: table reads (one RAM per component, both written by the builder)
  // ---------------------------------------------------------------------------
  logic [TBL_W-1:0] sin_v;
  logic [TBL_W-1:0] cos_v;
  logic             s1_sin_neg_q;
  logic             s1_cos_neg_q;
  logic             s1_top_q;

  nco_ram #(
    .WIDTH (TBL_W),
    .DEPTH (DEPTH)
  ) u_sin_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_addr),
    .wdata_i (fill_data),
    .re_i    (en1),
    .raddr_i (addr_sin),
    .rdata_o (sin_v)
  );

  nco_ram #(
    .WIDTH (TBL_W),
    .DEPTH (DEPTH)
  ) u_cos_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_addr),
    .wdata_i (fill_data),
    .re_i    (en1),
    .raddr_i (addr_cos),
    .rdata_o (cos_v)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_sin_neg_q <= k_sin[TABLE_BITS-1];
      s1_cos_neg_q <= k_cos[TABLE_BITS-1];
      s1_top_q     <= acc_cur[PHASE_BITS-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: apply sign and scale by the amplitude
  // ---------------------------------------------------------------------------
  logic signed [15:0] amp_s;
  logic signed [15:0] sin_mag;
  logic signed [15:0] cos_mag;
  logic signed [15:0] t_sin;
  logic signed [15:0] t_cos;
  logic signed [31:0] im_prod;
  logic signed [31:0] re_prod;
  logic signed [31:0] s2_im_prod_q;
  logic signed [31:0] s2_re_prod_q;
  logic               s2_top_q;

  assign amp_s   = {1'b0, amp_q};
  assign sin_mag = {1'b0, sin_v};
  assign cos_mag = {1'b0, cos_v};
  assign t_sin   = s1_sin_neg_q ? -sin_mag : sin_mag;
  assign t_cos   = s1_cos_neg_q ? -cos_mag : cos_mag;
  assign im_prod = amp_s * t_sin;
  assign re_prod = amp_s * t_cos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_im_prod_q <= im_prod;
      s2_re_prod_q <= re_prod;
      s2_top_q     <= s1_top_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: round, pick the waveform, saturate, output register
  // ---------------------------------------------------------------------------
  logic [31:0]                   re_sum;
  logic [31:0]                   im_sum;
  logic signed [16:0]            re_scaled;
  logic signed [16:0]            im_scaled;
  logic signed [16:0]            amp17;
  logic signed [16:0]            square;
  logic [SAMPLE_BITS-1:0]        real_d;
  logic [SAMPLE_BITS-1:0]        imag_d;
  logic signed [SAMPLE_BITS-1:0] real_q;
  logic signed [SAMPLE_BITS-1:0] imag_q;

  // Add half an LSB, then floor by the arithmetic shift.
  assign re_sum    = s2_re_prod_q + 32'sd16384;
  assign im_sum    = s2_im_prod_q + 32'sd16384;
  assign re_scaled = re_sum[31:15];
  assign im_scaled = im_sum[31:15];
  assign amp17     = {2'b00, amp_q};
  assign square    = s2_top_q ? -amp17 : amp17;
  assign real_d    = sat_sample(wave_q ? square : re_scaled);
  assign imag_d    = wave_q ? '0 : sat_sample(im_scaled);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en3) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      real_q <= real_d;
      imag_q <= imag_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign real_part_o = real_q;
  assign imag_part_o = imag_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_sample_during_fill: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    fill_busy |-> (!s1_valid_q && !s2_valid_q && !out_valid_q)
  ) else $error("sample in flight while the table is being built");

  a_square_imag_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && wave_q) |-> (imag_q == '0)
  ) else $error("square mode produced a nonzero imaginary part");

  a_stage2_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !en2) |=> (s2_valid_q && $stable(s2_re_prod_q) && $stable(s2_im_prod_q))
  ) else $error("stage 2 lost or changed its sample while blocked");

  a_out_from_stage2: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_valid_q)
  ) else $error("output became valid without a sample in stage 2");

endmodule

>>> test/nco_waveform_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for nco_waveform_generator: random sample requests
// and register settings, with results checked against an in-bench tone model.
// Depends on nco_pkg and the nco_waveform_generator RTL.
module nco_waveform_generator_tb;
  import nco_pkg::*;

  localparam int PHASE_BITS   = 32;
  localparam int TABLE_BITS   = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int QUARTER_BITS = TABLE_BITS - 2;
  localparam int LATENCY      = 3;
  localparam int RESET_CYCLES = 12;
  localparam int TARGET_REQS  = 2000;
  localparam int MAX_REPORTS  = 10;

  // Waveform select codes.
  localparam logic WAVE_SINE   = 1'b0;
  localparam logic WAVE_SQUARE = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
  } sample_t;

  // Tone model plus the queue of samples still owed by the block.
  class nco_sample_checker;
    logic [PHASE_BITS-1:0] acc;
    logic [PHASE_BITS-1:0] step;
    logic [PHASE_BITS-1:0] offset;
    logic [AMP_W-1:0]      amp;
    logic                  wave;
    sample_t               owed_samples[$];
    int                    errors;
    int                    checked;

    function new();
      acc     = '0;
      step    = '0;
      offset  = '0;
      amp     = '0;
      wave    = WAVE_SINE;
      errors  = 0;
      checked = 0;
    endfunction

    function int pending();
      return owed_samples.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (cfg_reg_e'(idx))
        REG_PHASE_STEP:   step   = data[PHASE_BITS-1:0];
        REG_PHASE_OFFSET: offset = data[PHASE_BITS-1:0];
        REG_AMPLITUDE:    amp    = data[AMP_W-1:0];
        REG_WAVEFORM:     wave   = data[0];
        default: ;
      endcase
    endfunction

    // (a*b) >> 62 on Q62 fixed-point operands.
    function logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
    endfunction

    // round(32767 * sin(pi/2 * m / 2^QUARTER_BITS)) by a Taylor series.
    function int quarter_sine(logic [63:0] m);
      logic [63:0] x, x2, term, sum, div;
      int n;
      x = q62_mul(HALF_PI_Q62, m << (62 - QUARTER_BITS));
      x2 = q62_mul(x, x);
      term = x;
      sum = x;
      for (n = 1; n <= int'(TAYLOR_TERMS); n++) begin
        div = 64'((2 * n) * (2 * n + 1));
        term = q62_mul(term, x2) / div;
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      sum = sum >> 22;
      return int'((64'd32767 * sum + (64'd1 << 39)) >> 40);
    endfunction

    // Full-turn table value, folded onto the quarter wave.
    function int sine_value(logic [TABLE_BITS-1:0] k);
      logic [1:0]  quad;
      logic [63:0] r;
      logic [63:0] qsize;
      int v;
      qsize = 64'd1 << QUARTER_BITS;
      quad = k[TABLE_BITS-1 -: 2];
      r = 64'(k[QUARTER_BITS-1:0]);
      v = quarter_sine(quad[0] ? qsize - r : r);
      return quad[1] ? -v : v;
    endfunction

    // Round and floor-shift A*T when scale is set, then clamp to the sample width.
    function logic signed [SAMPLE_BITS-1:0] to_sample(int v, bit scale);
      int hi;
      hi = (1 << (SAMPLE_BITS - 1)) - 1;
      if (scale) v = (int'(amp) * v + 16384) >>> 15;
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return v[SAMPLE_BITS-1:0];
    endfunction

    function void note_request(logic restart);
      sample_t want;
      logic [PHASE_BITS-1:0] ph;
      logic [TABLE_BITS-1:0] k, kc;
      if (restart) acc = '0;
      if (wave == WAVE_SQUARE) begin
        want.re = to_sample(acc[PHASE_BITS-1] ? -int'(amp) : int'(amp), 1'b0);
        want.im = '0;
      end else begin
        ph = acc + offset;
        k = ph[PHASE_BITS-1 -: TABLE_BITS];
        kc = k + TABLE_BITS'(1 << QUARTER_BITS);
        want.re = to_sample(sine_value(kc), 1'b1);
        want.im = to_sample(sine_value(k), 1'b1);
      end
      owed_samples.push_back(want);
      acc = acc + step;
    endfunction

    function void fault(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void check_sample(logic signed [SAMPLE_BITS-1:0] re,
                               logic signed [SAMPLE_BITS-1:0] im);
      sample_t want;
      if (owed_samples.size() == 0) begin
        fault($sformatf("unexpected sample re=%0d im=%0d", re, im));
        return;
      end
      want = owed_samples.pop_front();
      if (want.re !== re)
        fault($sformatf("sample %0d real_part: expected %0d, got %0d",
                        checked, want.re, re));
      if (want.im !== im)
        fault($sformatf("sample %0d imag_part: expected %0d, got %0d",
                        checked, want.im, im));
      checked++;
    endfunction
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]         cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic                          restart_i   = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] real_part_o;
  logic signed [SAMPLE_BITS-1:0] imag_part_o;

  nco_sample_checker tones = new();

  // Gaps and stalls are only inserted while this is set.
  bit gaps_on = 1'b1;
  int stall_left = 0;

  nco_waveform_generator #(
    .PHASE_BITS (PHASE_BITS),
    .TABLE_BITS (TABLE_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .real_part_o(real_part_o),
    .imag_part_o(imag_part_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Observe every edge: register writes, request transfers and sample
  // transfers all go to the model in the order the block sees them.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) tones.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) tones.note_request(restart_i);
      if (out_valid_o && !out_stall_i) tones.check_sample(real_part_o, imag_part_o);
    end
  end

  // Receiver back-pressure: alternate free-running stretches with stalls.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      if (!gaps_on || $urandom_range(0, 1) == 0) begin
        out_stall_i <= 1'b0;
        stall_left = $urandom_range(1, 30);
      end else begin
        out_stall_i <= 1'b1;
        stall_left = gap_length();
      end
    end else begin
      stall_left--;
    end
  end

  // Write one register; drop the enable again on the following cycle.
  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Issue count requests; restart each with restart_pct percent chance,
  // force it on the first one when first_restart is set. Valid stays high
  // after the last transfer; settle() drops it.
  task automatic send_requests(int count, int restart_pct, bit first_restart);
    int idle;
    for (int i = 0; i < count; i++) begin
      idle = (gaps_on && $urandom_range(0, 3) == 0) ? gap_length() : 0;
      if (idle > 0) begin
        in_valid_i <= 1'b0;
        restart_i  <= 1'($urandom_range(0, 1));
        repeat (idle) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      restart_i  <= (i == 0 && first_restart) ||
                    (int'($urandom_range(0, 99)) < restart_pct);
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every owed sample, then let the pipe empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tones.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Pick a fresh register setting; extremes come up often.
  task automatic retune();
    logic [31:0] v;
    logic [AMP_W-1:0] a;
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = '1;
        2:       v = 32'h8000_0000;
        3, 4:    v = $urandom_range(1, 1 << 16);
        5:       v = -$urandom_range(1, 1 << 16);
        default: v = $urandom();
      endcase
      program_reg(REG_PHASE_STEP, v);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0:       v = '0;
        1:       v = '1;
        default: v = $urandom();
      endcase
      program_reg(REG_PHASE_OFFSET, v);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0:       a = '0;
        1:       a = '1;
        2:       a = AMP_W'($urandom_range(1, 15));
        default: a = AMP_W'($urandom());
      endcase
      program_reg(REG_AMPLITUDE, ($urandom() & ~32'h7FFF) | 32'(a));
    end
    if ($urandom_range(0, 2) != 0)
      program_reg(REG_WAVEFORM, ($urandom() & ~32'h1) |
                  32'(($urandom_range(0, 9) < 3) ? WAVE_SQUARE : WAVE_SINE));
    // Writes to indexes past the last register must leave everything alone.
    if ($urandom_range(0, 2) == 0)
      program_reg(CFG_IDX_W'($urandom_range(int'(REG_WAVEFORM) + 1,
                                            (1 << CFG_IDX_W) - 1)),
                  $urandom());
  endtask

  initial begin
    int sent;
    int batch;
    sent = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: zero amplitude sine, so every sample is zero. The first
    // request also waits out the table fill.
    send_requests(1, 0, 1'b0);
    send_requests(1, 0, 1'b1);
    settle();

    // Full scale, quarter-turn step: hit both peaks and every quadrant edge.
    program_reg(REG_PHASE_STEP, 32'h4000_0000);
    program_reg(REG_AMPLITUDE, 32'h0000_7FFF);
    send_requests(5, 0, 1'b1);
    settle();

    // All-ones step and offset; bits above each register's width ignored.
    program_reg(REG_PHASE_STEP, '1);
    program_reg(REG_PHASE_OFFSET, '1);
    program_reg(REG_AMPLITUDE, '1);
    program_reg(REG_WAVEFORM, 32'hFFFF_FFFE);
    send_requests(4, 0, 1'b1);
    settle();

    // Square wave at minimum nonzero amplitude, half-turn step: the offset is unused.
    program_reg(REG_WAVEFORM, 32'(WAVE_SQUARE));
    program_reg(REG_PHASE_STEP, 32'h8000_0000);
    program_reg(REG_PHASE_OFFSET, $urandom());
    program_reg(REG_AMPLITUDE, 32'h0000_0001);
    send_requests(4, 0, 1'b1);
    settle();

    // Square wave at full scale; stray writes past the last index first.
    program_reg(REG_AMPLITUDE, 32'h0000_7FFF);
    program_reg(REG_PHASE_STEP, '1);
    for (int idx = int'(REG_WAVEFORM) + 1; idx < (1 << CFG_IDX_W); idx++)
      program_reg(CFG_IDX_W'(idx), '1);
    send_requests(3, 0, 1'b1);
    settle();
    program_reg(REG_AMPLITUDE, 32'hFFFF_8000);
    send_requests(2, 50, 1'b0);
    settle();

    // Random settings, each followed by a burst of requests.
    while (sent < TARGET_REQS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      retune();
      batch = $urandom_range(40, 120);
      case ($urandom_range(0, 2))
        0:       send_requests(batch, 0, 1'($urandom_range(0, 1)));
        1:       send_requests(batch, 2, 1'($urandom_range(0, 1)));
        default: send_requests(batch, 20, 1'($urandom_range(0, 1)));
      endcase
      sent += batch;
      settle();
    end

    if (tones.errors == 0 && tones.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop: covers the table fill after reset plus a slow, stalled run.
  initial begin
    #(64'd200_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> nco_waveform_generator.f
rtl/nco_pkg.sv
rtl/nco_ram.sv
rtl/nco_sine_fill.sv
rtl/nco_waveform_generator.sv
test/nco_waveform_generator_tb.sv
